@@ sv/esc_pkg.sv @@
// Package for the epoch-seconds to calendar converter.
// Holds the sequencer state type, the time constants and the calendar helpers.
// Depends on nothing else in the project.
package esc_pkg;

  localparam int EpochBits = 32;
  localparam int SubBits   = 32;   // width of the shared subtractor operands
  localparam int YsecBits  = 25;   // second of the year, below 31622400
  localparam int YearBits  = 12;

  localparam logic [SubBits-1:0]  YearSecs     = 32'd31536000;
  localparam logic [SubBits-1:0]  LeapYearSecs = 32'd31622400;
  localparam logic [SubBits-1:0]  DaySecs      = 32'd86400;
  localparam logic [SubBits-1:0]  HourSecs     = 32'd3600;
  localparam logic [SubBits-1:0]  MinSecs      = 32'd60;
  localparam logic [YsecBits-1:0] LeapDaySecs  = 25'd86400;
  localparam logic [YearBits-1:0] BaseYear     = 12'd1970;
  // The only century year between 1970 and 2106 that is not divisible by 400.
  localparam logic [YearBits-1:0] CenturyNoLeap = 12'd2100;
  localparam logic [YearBits-1:0] LastYear      = 12'd2106;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_YEAR  = 8'b0000_0010,
    ST_MONTH = 8'b0000_0100,
    ST_BASE  = 8'b0000_1000,
    ST_DAY   = 8'b0001_0000,
    ST_HOUR  = 8'b0010_0000,
    ST_MIN   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  // Gregorian leap rule, valid over the reachable years 1970 to 2106.
  function automatic logic is_leap(input logic [YearBits-1:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != CenturyNoLeap);
  endfunction

  // Second of a common year at which a month starts; month 0 is January.
  function automatic logic [YsecBits-1:0] month_start(input logic [3:0] m);
    case (m)
      4'd0:    month_start = 25'd0;
      4'd1:    month_start = 25'd2678400;
      4'd2:    month_start = 25'd5097600;
      4'd3:    month_start = 25'd7776000;
      4'd4:    month_start = 25'd10368000;
      4'd5:    month_start = 25'd13046400;
      4'd6:    month_start = 25'd15638400;
      4'd7:    month_start = 25'd18316800;
      4'd8:    month_start = 25'd20995200;
      4'd9:    month_start = 25'd23587200;
      4'd10:   month_start = 25'd26265600;
      4'd11:   month_start = 25'd28857600;
      default: month_start = 25'd0;
    endcase
  endfunction

endpackage

@@ sv/epoch_seconds_to_calendar.sv @@
// Sequence: from the accepting edge, one year step per whole year past 1970 plus one (at most
// 137), 11 month compares, a base step to take off the month start, 5 day steps, 5 hour steps,
// 6 minute steps and a final step in FIN to load the result, after which out_valid rises.
// One beat at a time: a new beat is taken only once the sequencer is back in idle, since the
// single shared 32-bit subtractor serves every phase; a stalled result held in FIN delays it.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module epoch_seconds_to_calendar (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [esc_pkg::EpochBits-1:0]  epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [esc_pkg::YearBits-1:0]   year,
  output logic [3:0]                     month,
  output logic [4:0]                     day,
  output logic [4:0]                     hour,
  output logic [5:0]                     minute,
  output logic [5:0]                     second
);
  import esc_pkg::*;

  state_t state;

  // Working registers of the sequencer.
  logic [EpochBits-1:0] secs;    // seconds still to be accounted for
  logic [YearBits-1:0]  yr;
  logic [3:0]           mon;
  logic [YsecBits-1:0]  mbase;   // first second of the chosen month within the year
  logic [4:0]           dy;      // zero-based day of the month
  logic [4:0]           hrs;
  logic [5:0]           mins;
  logic [3:0]           cnt;     // step counter shared by the month, day, hour and minute phases

  // The shared unit: one subtractor whose borrow doubles as the comparison.
  logic [SubBits-1:0]  sub_a;
  logic [SubBits-1:0]  sub_b;
  logic [SubBits:0]    diff;
  logic                ge;
  logic                leap;
  logic [YsecBits-1:0] mb_cand;
  logic                fin_load;

  assign leap    = is_leap(yr);
  // In a leap year every month from March on starts one day later.
  assign mb_cand = month_start(cnt) + (((cnt >= 4'd2) && leap) ? LeapDaySecs : '0);

  // Operand selection for the subtractor, one pair per phase. The remaining seconds are
  // always the minuend; only the subtrahend changes.
  always_comb begin
    sub_a = secs;
    case (state)
      ST_YEAR: begin
        sub_b = leap ? LeapYearSecs : YearSecs;
      end
      ST_MONTH: begin
        sub_b = SubBits'(mb_cand);
      end
      ST_BASE: begin
        sub_b = SubBits'(mbase);
      end
      ST_DAY: begin
        sub_b = DaySecs << cnt[2:0];
      end
      ST_HOUR: begin
        sub_b = HourSecs << cnt[2:0];
      end
      ST_MIN: begin
        sub_b = MinSecs << cnt[2:0];
      end
      default: begin
        sub_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[SubBits];

  // The block takes a new beat only when the sequencer is idle.
  assign in_stall = (state != ST_IDLE);

  // The result moves to the output registers once they are empty or being drained.
  assign fin_load = (state == ST_FIN) && (!out_valid || !out_stall);

  // Sequencer: whole years are taken off the seconds one at a time, then a compare walk
  // over the month starts picks the month, whose first second is then removed. Day, hour
  // and minute each come from a short compare-and-subtract against shifted constants,
  // one quotient bit per step, and what is left at the end is the second.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            secs  <= epoch_seconds;
            yr    <= BaseYear;
            state <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          if (ge) begin
            secs <= diff[SubBits-1:0];
            yr   <= yr + 12'd1;
          end else begin
            mon   <= 4'd1;
            mbase <= '0;
            cnt   <= 4'd1;
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          // The month starts rise, so the last start passed is the month.
          if (ge) begin
            mon   <= cnt + 4'd1;
            mbase <= mb_cand;
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd11) begin
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          secs  <= diff[SubBits-1:0];
          dy    <= '0;
          cnt   <= 4'd4;
          state <= ST_DAY;
        end
        ST_DAY: begin
          if (ge) begin
            secs <= diff[SubBits-1:0];
          end
          dy <= {dy[3:0], ge};
          if (cnt == 4'd0) begin
            hrs   <= '0;
            cnt   <= 4'd4;
            state <= ST_HOUR;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        ST_HOUR: begin
          if (ge) begin
            secs <= diff[SubBits-1:0];
          end
          hrs <= {hrs[3:0], ge};
          if (cnt == 4'd0) begin
            mins  <= '0;
            cnt   <= 4'd5;
            state <= ST_MIN;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        ST_MIN: begin
          if (ge) begin
            secs <= diff[SubBits-1:0];
          end
          mins <= {mins[4:0], ge};
          if (cnt == 4'd0) begin
            state <= ST_FIN;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a finished beat until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      year   <= yr;
      month  <= mon;
      day    <= dy + 5'd1;
      hour   <= hrs;
      minute <= mins;
      second <= secs[5:0];
    end
  end

  // A result appears only when the sequencer has just finished a beat.
  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("out_valid rose without a finished conversion");

  // An accepted beat always starts the year walk.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_YEAR))
    else $error("accepted beat did not start the year walk");

  // The year walk never runs past the last year a 32-bit count can reach.
  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (yr <= LastYear))
    else $error("year walk ran past its bound");

  // Every delivered date has a month from 1 to 12, a day of at least 1 and an hour of at most 23.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && hour <= 5'd23))
    else $error("delivered date out of range");

endmodule
